// ===== sv/sbie_pkg.sv =====
// Shared types and constants for the stop-bit integer encoder.
package sbie_pkg;

  // Integer type selector carried with each request.
  typedef enum logic [1:0] {
    CMD_UNSIGNED      = 2'd0,
    CMD_SIGNED        = 2'd1,
    CMD_NULL_UNSIGNED = 2'd2,
    CMD_NULL_SIGNED   = 2'd3
  } cmd_e;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned GROUP_W   = 7;
  localparam int unsigned MAX_BYTES = 10;
  localparam int unsigned WORD_W    = GROUP_W * MAX_BYTES;
  localparam int unsigned TOP_W     = WORD_W - VALUE_W;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int unsigned BYTE_W    = 8;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [TOP_W-1:0] TOP_SIGN_FILL = '1;

  // Classified request: the value widened to ten 7-bit groups.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              is_signed;
  } entry_t;

endpackage

// ===== sv/sbie_if.sv =====
// Valid/ready channel interfaces for the encoder input and output.
interface sbie_in_if import sbie_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_e               cmd;
  logic [VALUE_W-1:0] value;
  logic               is_null;

  modport source(output valid, cmd, value, is_null, input ready);
  modport sink(input valid, cmd, value, is_null, output ready);
endinterface

interface sbie_out_if import sbie_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source(output valid, out_byte, last, input ready);
  modport sink(input valid, out_byte, last, output ready);
endinterface

// ===== sv/sbie_front.sv =====
// Front end: accepts requests and turns each into a 70-bit group word.
module sbie_front import sbie_pkg::*; (
  sbie_in_if.sink in_i,
  output logic   push_valid_o,
  input  logic   push_ready_i,
  output entry_t push_entry_o
);

  logic           sgn;
  logic           nullable;
  logic           neg;
  logic [VALUE_W:0] inc;
  entry_t         entry;

  always_comb begin
    sgn      = (in_i.cmd == CMD_SIGNED) || (in_i.cmd == CMD_NULL_SIGNED);
    nullable = (in_i.cmd == CMD_NULL_UNSIGNED) || (in_i.cmd == CMD_NULL_SIGNED);
    neg      = in_i.value[VALUE_W-1];
    inc      = {1'b0, in_i.value} + {{VALUE_W{1'b0}}, 1'b1};
    entry.is_signed = sgn;
    entry.word      = {{TOP_W{1'b0}}, in_i.value};
    if (nullable && in_i.is_null) begin
      // A null is a zero word with one group, which gives the lone stop byte.
      entry.is_signed = 1'b0;
      entry.word      = '0;
    end else if (sgn) begin
      if (neg) begin
        entry.word = {TOP_SIGN_FILL, in_i.value};
      end else if (nullable) begin
        entry.word = {{TOP_W{1'b0}}, inc[VALUE_W-1:0]};
      end
    end else if (nullable) begin
      entry.word = {{(TOP_W-1){1'b0}}, inc};
    end
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign push_entry_o = entry;

endmodule

// ===== sv/sbie_fifo.sv =====
// Short queue between the front end and the byte serializer.
module sbie_fifo import sbie_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_entry_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_entry_o
);

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = push ? ptr_next(wptr_q) : wptr_q;
    rptr_d = pop ? ptr_next(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== sv/sbie_back.sv =====
// Back end: sizes a group word and sends it out one byte per cycle while the receiver is ready.
module sbie_back import sbie_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  entry_t    pop_entry_i,
  sbie_out_if.source out_o
);

  logic [WORD_W-1:0] word_q, word_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  size;
  logic              advance;
  logic              load;

  // Fewest groups that hold the word; sign-extension for signed types.
  function automatic logic [CNT_W-1:0] group_count(entry_t e);
    logic [WORD_W-1:0] ones;
    logic [WORD_W-1:0] want;
    logic [CNT_W-1:0]  n;
    ones = '1;
    n    = CNT_W'(MAX_BYTES);
    for (int i = MAX_BYTES - 1; i >= 1; i--) begin
      if (e.is_signed) begin
        want = e.word[WORD_W-1] ? (ones >> (GROUP_W * i - 1)) : '0;
        if ((e.word >> (GROUP_W * i - 1)) == want) begin
          n = CNT_W'(i);
        end
      end else if ((e.word >> (GROUP_W * i)) == '0) begin
        n = CNT_W'(i);
      end
    end
    return n;
  endfunction

  assign size        = group_count(pop_entry_i);
  assign out_o.valid = (cnt_q != '0);
  assign advance     = out_o.valid && out_o.ready;
  assign load        = pop_valid_i && ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && advance));
  assign pop_ready_o = load;

  assign out_o.last     = (cnt_q == CNT_W'(1));
  assign out_o.out_byte = {out_o.last, word_q[WORD_W-1 -: GROUP_W]};

  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    if (load) begin
      // Left-align the leading group so it sits in the top seven bits.
      word_d = pop_entry_i.word << (GROUP_W * (MAX_BYTES - int'(size)));
      cnt_d  = size;
    end else if (advance) begin
      word_d = word_q << GROUP_W;
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// ===== sv/stop_bit_integer_encoder_top.sv =====
// Top level of the stop-bit integer encoder.
//
//   channel  direction  payload               one request is
//   in_i     sink       cmd, value, is_null   one integer to encode
//   out_o    source     out_byte, last        one encoded byte
//
// An integer produces 1 to 10 bytes and the serializer sends one byte per
// cycle while out_o is ready; when the next integer is already queued, its
// first byte follows its predecessor's last byte with no gap.
// The front end classifies and widens each request in the cycle it is taken;
// the request is stored in the queue and then loaded into the serializer's
// registers, from which its first byte is offered. Reset empties the queue and
// the serializer. A stalled output only fills the two-entry queue before in_i
// drops ready.
module stop_bit_integer_encoder_top import sbie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbie_in_if.sink    in_i,
  sbie_out_if.source out_o
);

  // Front end to queue.
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;

  // Queue to serializer.
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  // The front end widens the value to 70 bits: sign fill for negative signed
  // values and the increment (with its carry) for non-null nullable values that are not negative.
  sbie_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // The queue lets intake continue while a long encoding is still draining.
  sbie_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // The serializer picks the byte count and emits the groups, most
  // significant first, with the stop bit on the final byte.
  sbie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

endmodule

// ===== tb/sbie_checker.sv =====
// Checker for the stop-bit integer encoder: predicts the byte stream and compares it.
module sbie_checker import sbie_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sbie_in_if   in_mon,
  sbie_out_if  out_mon,
  output int   n_errors_o,
  output int   n_pending_o,
  output int   n_ints_o,
  output int   n_bytes_o
);

  localparam logic [BYTE_W-1:0] STOP_BIT = 8'h80;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } enc_byte_t;

  enc_byte_t pending_bytes_q[$];
  int        err_cnt;
  int        int_cnt;
  int        byte_cnt;

  // Appends the bytes that one integer encodes to.
  function automatic void queue_encoding(cmd_e cmd, logic [VALUE_W-1:0] value,
                                         logic is_null);
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] fill;
    logic              signed_op;
    logic              nullable;
    logic              negative;
    int                n;
    enc_byte_t         b;
    signed_op = (cmd == CMD_SIGNED) || (cmd == CMD_NULL_SIGNED);
    nullable  = (cmd == CMD_NULL_UNSIGNED) || (cmd == CMD_NULL_SIGNED);
    negative  = signed_op && value[VALUE_W-1];
    if (nullable && is_null) begin
      b.out_byte = STOP_BIT;
      b.last     = 1'b1;
      pending_bytes_q.push_back(b);
      return;
    end
    word = negative ? {{TOP_W{1'b1}}, value} : {{TOP_W{1'b0}}, value};
    // The increment is done in the full 70-bit word, so it never wraps.
    if (nullable && !negative) word = word + 1'b1;
    fill = word[WORD_W-1] ? '1 : '0;
    n = MAX_BYTES;
    for (int k = MAX_BYTES - 1; k >= 1; k--) begin
      if (signed_op) begin
        if ((word >> (GROUP_W * k - 1)) == (fill >> (GROUP_W * k - 1))) n = k;
      end else begin
        if ((word >> (GROUP_W * k)) == '0) n = k;
      end
    end
    for (int i = n - 1; i >= 0; i--) begin
      b.out_byte = {i == 0, word[GROUP_W * i +: GROUP_W]};
      b.last     = (i == 0);
      pending_bytes_q.push_back(b);
    end
  endfunction

  function automatic void b_check(enc_byte_t want);
    if (want.out_byte !== out_mon.out_byte || want.last !== out_mon.last) begin
      err_cnt++;
      $display("%0t checker: byte mismatch, expected %02h last %0b, got %02h last %0b",
               $time, want.out_byte, want.last, out_mon.out_byte, out_mon.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_bytes_q.delete();
      err_cnt  = 0;
      int_cnt  = 0;
      byte_cnt = 0;
    end else begin
      // Bytes are checked before new integers are queued at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        byte_cnt++;
        if (pending_bytes_q.size() == 0) begin
          err_cnt++;
          $display("%0t checker: unexpected byte, expected none, got %02h last %0b",
                   $time, out_mon.out_byte, out_mon.last);
        end else begin
          b_check(pending_bytes_q.pop_front());
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        int_cnt++;
        queue_encoding(in_mon.cmd, in_mon.value, in_mon.is_null);
      end
    end
    n_errors_o  <= err_cnt;
    n_pending_o <= pending_bytes_q.size();
    n_ints_o    <= int_cnt;
    n_bytes_o   <= byte_cnt;
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the stop-bit integer encoder: stimulus, back-pressure and verdict.
module tb import sbie_pkg::*; ();

  // Number of random integers after the directed part.
  localparam int RANDOM_INTS = 400;
  // The last part of the run has no idling on either side.
  localparam int QUIET_INTS  = 60;
  // Cycles with no handshake on either channel before the run is abandoned.
  // The longest legal gap is a sender burst plus a receiver burst, well under this.
  localparam int STALL_LIMIT = 1000;
  // Settling time after the last byte; the encoder offers the first byte of a
  // request once it has passed through the queue and the serializer.
  localparam int DRAIN_CYCLES = 20;

  logic clk_i;
  logic rst_ni;
  logic quiet_phase;
  int   n_errors;
  int   n_pending;
  int   n_ints;
  int   n_bytes;
  int   idle_cycles;

  sbie_in_if  in_bus ();
  sbie_out_if out_bus ();

  stop_bit_integer_encoder_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  sbie_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .n_errors_o  (n_errors),
    .n_pending_o (n_pending),
    .n_ints_o    (n_ints),
    .n_bytes_o   (n_bytes)
  );

  // Free-running clock with a period of 10.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Puts one integer on the request channel at the falling edge and holds it
  // until a rising edge sees ready. Ready is sampled at the rising edge, before
  // the encoder's registers move, so the sample is the value the handshake used.
  task automatic send_int(cmd_e cmd, logic [VALUE_W-1:0] value, logic is_null);
    @(negedge clk_i);
    in_bus.valid   <= 1'b1;
    in_bus.cmd     <= cmd;
    in_bus.value   <= value;
    in_bus.is_null <= is_null;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  // Drops valid for a burst of random length. Only one assignment to valid
  // falls on each falling edge, so valid never dips and rises in one step.
  task automatic idle_sender();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    repeat ($urandom_range(0, 5)) @(negedge clk_i);
  endtask

  // Holds off new requests until every predicted byte has come out.
  // The pending count is read at the falling edge, away from the checker's update.
  task automatic drain_encoder();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk_i);
  endtask

  // Random values spread over every encoded length, with boundary values at
  // each 7-bit group edge and the 64-bit extremes; half are inverted so that
  // signed commands see negatives of every length too.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    int                 nbits;
    int                 k;
    case ($urandom_range(0, 7))
      0: begin
        k = $urandom_range(1, MAX_BYTES - 1);
        v = (64'd1 << (GROUP_W * k)) - 64'd2 + 64'($urandom_range(0, 2));
      end
      1: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          2: v = 64'h8000_0000_0000_0000;
          default: v = 64'h7fff_ffff_ffff_ffff;
        endcase
      end
      default: begin
        nbits = $urandom_range(0, VALUE_W);
        v = {$urandom, $urandom};
        if (nbits < VALUE_W) v &= (64'd1 << nbits) - 64'd1;
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = ~v;
    return v;
  endfunction

  // Receiver: ready drops for random bursts, never in the quiet part.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t tb: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_e               cmd;
    logic [VALUE_W-1:0] value;
    logic               is_null;
    // Every input is at a known level from time zero.
    rst_ni         <= 1'b0;
    quiet_phase    <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.cmd     <= CMD_UNSIGNED;
    in_bus.value   <= '0;
    in_bus.is_null <= 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part. Unsigned: zero, one- and two-byte edges, the largest
    // value and the top bit alone.
    send_int(CMD_UNSIGNED, 64'd0, 1'b0);
    send_int(CMD_UNSIGNED, 64'd127, 1'b0);
    send_int(CMD_UNSIGNED, 64'd128, 1'b0);
    send_int(CMD_UNSIGNED, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_int(CMD_UNSIGNED, 64'h8000_0000_0000_0000, 1'b0);
    // Signed: sign edges of the first group, the minimum (ten bytes, first
    // one 0x7f) and the maximum.
    send_int(CMD_SIGNED, 64'd0, 1'b0);
    send_int(CMD_SIGNED, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_int(CMD_SIGNED, 64'd63, 1'b0);
    send_int(CMD_SIGNED, 64'd64, 1'b0);
    send_int(CMD_SIGNED, 64'hffff_ffff_ffff_ffc0, 1'b0);
    send_int(CMD_SIGNED, 64'hffff_ffff_ffff_ffbf, 1'b0);
    send_int(CMD_SIGNED, 64'h8000_0000_0000_0000, 1'b0);
    send_int(CMD_SIGNED, 64'h7fff_ffff_ffff_ffff, 1'b0);
    // Nullable unsigned: a null with a nonzero value behind it, zero, the
    // one-byte edge after the increment, and the maximum, whose increment
    // carries out of 64 bits into a ten-byte code led by 0x02.
    send_int(CMD_NULL_UNSIGNED, 64'h0123_4567_89ab_cdef, 1'b1);
    send_int(CMD_NULL_UNSIGNED, 64'd0, 1'b0);
    send_int(CMD_NULL_UNSIGNED, 64'd126, 1'b0);
    send_int(CMD_NULL_UNSIGNED, 64'd127, 1'b0);
    send_int(CMD_NULL_UNSIGNED, 64'hffff_ffff_ffff_ffff, 1'b0);
    // Nullable signed: null, a negative (not incremented), zero, the sign
    // edge after the increment, and the maximum, which becomes 2^63 and stays
    // positive in ten bytes led by 0x01.
    send_int(CMD_NULL_SIGNED, 64'hffff_ffff_ffff_ffff, 1'b1);
    send_int(CMD_NULL_SIGNED, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_int(CMD_NULL_SIGNED, 64'd0, 1'b0);
    send_int(CMD_NULL_SIGNED, 64'd63, 1'b0);
    send_int(CMD_NULL_SIGNED, 64'h7fff_ffff_ffff_ffff, 1'b0);
    // A null flag on a plain command is ignored and the value is encoded.
    send_int(CMD_UNSIGNED, 64'd5, 1'b1);
    send_int(CMD_SIGNED, 64'hffff_ffff_ffff_ffff, 1'b1);

    // Let the directed bytes come out before the random part starts.
    drain_encoder();

    for (int i = 0; i < RANDOM_INTS; i++) begin
      if (i == RANDOM_INTS / 2) drain_encoder();
      if (i == RANDOM_INTS - QUIET_INTS) quiet_phase <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 5) == 0) idle_sender();
      cmd     = cmd_e'($urandom_range(int'(CMD_NULL_SIGNED), int'(CMD_UNSIGNED)));
      value   = pick_value();
      is_null = ($urandom_range(0, 3) == 0);
      send_int(cmd, value, is_null);
    end

    drain_encoder();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("tb: %0d integers over all four types (extremes, nulls, group edges, random lengths),",
             n_ints);
    $display("tb: %0d encoded bytes compared, %0d mismatches", n_bytes, n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
